>>> hdl/ttc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared widths, types and register codes of the triangle transform block.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int COORD_BITS = 16;       // screen coordinate width, Q.4
  localparam int SLOT_BITS  = 16;       // slot counter width
  localparam int VW         = 16;       // Q8.8 vertex and camera fields
  localparam int CW         = 16;       // Q2.14 matrix coefficients
  localparam int RegW       = 48;       // packed three-field registers
  localparam int SizeW      = 12;       // width, height, focal
  localparam int PW         = VW + CW;  // one rotation product
  localparam int SW         = PW + 2;   // sum of three products
  localparam int TW         = 21;       // rotated coordinate, Q.8
  localparam int EW         = TW + 1;   // edge and camera vector
  localparam int MW         = 2 * EW;   // cross product term
  localparam int NW         = MW + 1;   // normal component
  localparam int NLW        = 23;       // low part of a normal component
  localparam int NHW        = NW - NLW; // high part of a normal component
  localparam int PLW        = NLW + 1 + EW;
  localparam int PHW        = NHW + EW;
  localparam int DOTW       = PHW + NLW + 3;
  localparam int NUMP       = TW + SizeW + 1;  // coord * focal, signed
  localparam int NUMW       = NUMP + 4;        // magnitude * 16
  localparam int ZW         = TW;              // divisor width
  localparam int QB         = NUMW;            // quotient bits, one per stage
  localparam int QSW        = NUMW + 2;        // signed, floored quotient
  localparam int ZOffset    = 1280;            // 5.0 in Q.8
  localparam int ShiftQ     = 14;

  // Pipeline positions (index of the stage register holding the item)
  localparam int KEEP_IDX   = 6;
  localparam int LAST       = QB + 4;

  localparam logic [2:0] REG_ROT_X  = 3'd0;
  localparam logic [2:0] REG_ROT_Y  = 3'd1;
  localparam logic [2:0] REG_ROT_Z  = 3'd2;
  localparam logic [2:0] REG_CAMERA = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_FOCAL  = 3'd6;

  typedef logic signed [VW-1:0]         vcoord_t;
  typedef logic signed [TW-1:0]         tcoord_t;
  typedef logic signed [COORD_BITS-1:0] scoord_t;
  typedef logic [SizeW-1:0]             size_t;

endpackage

>>> hdl/ttc_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc channel interfaces
// Triangle input, screen result and configuration write channels.
// ----------------------------------------------------------------------------
interface ttc_tri_if import ttc_pkg::*; ();
  logic    valid;
  logic    ready;
  vcoord_t vert_a_x, vert_a_y, vert_a_z;
  vcoord_t vert_b_x, vert_b_y, vert_b_z;
  vcoord_t vert_c_x, vert_c_y, vert_c_z;
  logic    frame_start;

  modport source (output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                  vert_b_z, vert_c_x, vert_c_y, vert_c_z, frame_start, input ready);
  modport sink (input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                vert_b_z, vert_c_x, vert_c_y, vert_c_z, frame_start, output ready);
endinterface

interface ttc_scr_if import ttc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  scoord_t              scr_a_x, scr_a_y, scr_b_x, scr_b_y, scr_c_x, scr_c_y;
  logic [SLOT_BITS-1:0] slot;
  logic                 behind_camera;

  modport source (output valid, scr_a_x, scr_a_y, scr_b_x, scr_b_y, scr_c_x, scr_c_y,
                  slot, behind_camera, input ready);
  modport sink (input valid, scr_a_x, scr_a_y, scr_b_x, scr_b_y, scr_c_x, scr_c_y,
                slot, behind_camera, output ready);
endinterface

interface ttc_cfg_if import ttc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [2:0]      index;
  logic [RegW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/ttc_rotate_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_rotate_lane
// Rotates one corner by the 3x3 matrix and offsets z by 5.0. Two stages.
// ----------------------------------------------------------------------------
module ttc_rotate_lane import ttc_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  vcoord_t                   v_x,
  input  vcoord_t                   v_y,
  input  vcoord_t                   v_z,
  input  logic [2:0][RegW-1:0]      rot,
  output tcoord_t                   t [3]
);

  logic signed [PW-1:0] prod [3][3];
  logic signed [SW-1:0] sum  [3];
  vcoord_t              v    [3];

  assign v[0] = v_x;
  assign v[1] = v_y;
  assign v[2] = v_z;

  // Stage 1: nine independent products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(rot[r][CW*c +: CW]) * v[c];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SW'(prod[r][0]) + SW'(prod[r][1]) + SW'(prod[r][2]);
    end
  end

  // Stage 2: floor to Q.8, offset z
  always_ff @(posedge clk) begin
    if (en) begin
      t[0] <= TW'(sum[0] >>> ShiftQ);
      t[1] <= TW'(sum[1] >>> ShiftQ);
      t[2] <= TW'(sum[2] >>> ShiftQ) + TW'(ZOffset);
    end
  end

endmodule

>>> hdl/ttc_cull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_cull
// Merges the three corner lanes: normal (B-A)x(C-A) dotted with (camera-A).
// Five stages; keep is high when the dot product is positive.
// ----------------------------------------------------------------------------
module ttc_cull import ttc_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  tcoord_t         tv [3][3],
  input  logic [RegW-1:0] camera,
  output logic            keep
);

  logic signed [EW-1:0]   e1 [3], e2 [3];
  logic signed [EW-1:0]   cm1 [3], cm2 [3], cm3 [3];
  logic signed [MW-1:0]   m  [6];
  logic signed [NW-1:0]   n  [3];
  logic signed [PLW-1:0]  pl [3];
  logic signed [PHW-1:0]  ph [3];
  logic signed [DOTW-1:0] dot;

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: edges and camera vector
      for (int k = 0; k < 3; k++) begin
        e1[k]  <= EW'(tv[1][k]) - EW'(tv[0][k]);
        e2[k]  <= EW'(tv[2][k]) - EW'(tv[0][k]);
        cm1[k] <= EW'($signed(camera[VW*k +: VW])) - EW'(tv[0][k]);
      end
      // Stage 2: cross product terms
      m[0] <= e1[1] * e2[2];
      m[1] <= e1[2] * e2[1];
      m[2] <= e1[2] * e2[0];
      m[3] <= e1[0] * e2[2];
      m[4] <= e1[0] * e2[1];
      m[5] <= e1[1] * e2[0];
      cm2  <= cm1;
      // Stage 3: normal
      for (int k = 0; k < 3; k++) begin
        n[k] <= NW'(m[2*k]) - NW'(m[2*k+1]);
      end
      cm3 <= cm2;
      // Stage 4: split products of the dot
      for (int k = 0; k < 3; k++) begin
        pl[k] <= $signed({1'b0, n[k][NLW-1:0]}) * cm3[k];
        ph[k] <= $signed(n[k][NW-1:NLW]) * cm3[k];
      end
      // Stage 5: sign of the dot
      keep <= (dot > 0);
    end
  end

  always_comb begin
    dot = '0;
    for (int k = 0; k < 3; k++) begin
      dot = dot + (DOTW'(ph[k]) <<< NLW) + DOTW'(pl[k]);
    end
  end

endmodule

>>> hdl/ttc_proj_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_proj_lane
// Projects one coordinate: floor(c*focal*16/z) + size*8, saturated; zero when z <= 0.
// A restoring divider gives one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ttc_proj_lane import ttc_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  tcoord_t c,
  input  tcoord_t z,
  input  size_t   focal,
  input  size_t   size,
  output scoord_t res,
  output logic    behind
);

  localparam logic signed [QSW-1:0] SatHi = QSW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [QSW-1:0] SatLo = -QSW'(64'sd1 <<< (COORD_BITS - 1));

  logic signed [NUMP-1:0] num;
  tcoord_t                zr;
  logic [NUMP-1:0]        mag_abs;
  logic [NUMW-1:0]        mag;
  logic                   neg0;
  logic                   zpos0;
  logic [ZW-1:0]          dz0;

  logic [ZW-1:0]   rem  [QB];
  logic [NUMW-1:0] dvd  [QB];
  logic [NUMW-1:0] quo  [QB];
  logic [ZW-1:0]   dzp  [QB];
  logic            negp [QB];
  logic            zpp  [QB];

  logic [ZW:0]           trial [QB];
  logic                  qbit  [QB];
  logic [ZW-1:0]         rin   [QB];
  logic [NUMW-1:0]       din   [QB];
  logic [NUMW-1:0]       qin   [QB];
  logic [ZW-1:0]         zin   [QB];
  logic signed [QSW-1:0] qs;
  logic signed [QSW-1:0] pos;

  assign mag_abs = num[NUMP-1] ? NUMP'(-num) : NUMP'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      num   <= NUMP'(c * $signed({1'b0, focal}));
      zr    <= z;
      mag   <= {mag_abs, 4'b0000};
      neg0  <= num[NUMP-1];
      zpos0 <= (zr > 0);
      dz0   <= zr;
    end
  end

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      rin[k]   = (k == 0) ? '0   : rem[(k == 0) ? 0 : k-1];
      din[k]   = (k == 0) ? mag  : dvd[(k == 0) ? 0 : k-1];
      qin[k]   = (k == 0) ? '0   : quo[(k == 0) ? 0 : k-1];
      zin[k]   = (k == 0) ? dz0  : dzp[(k == 0) ? 0 : k-1];
      trial[k] = {rin[k], din[k][NUMW-1]};
      qbit[k]  = (trial[k] >= {1'b0, zin[k]});
    end
  end

  // One quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        rem[k]  <= qbit[k] ? ZW'(trial[k] - {1'b0, zin[k]}) : ZW'(trial[k]);
        dvd[k]  <= {din[k][NUMW-2:0], 1'b0};
        quo[k]  <= {qin[k][NUMW-2:0], qbit[k]};
        dzp[k]  <= zin[k];
        negp[k] <= (k == 0) ? neg0  : negp[(k == 0) ? 0 : k-1];
        zpp[k]  <= (k == 0) ? zpos0 : zpp[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Floor for negative numerators, center, saturate
  always_comb begin
    qs  = QSW'(quo[QB-1]);
    if (negp[QB-1]) begin
      qs = -(qs + QSW'(rem[QB-1] != '0));
    end
    pos = qs + QSW'({size, 3'b000});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      behind <= !zpp[QB-1];
      if (!zpp[QB-1]) begin
        res <= '0;
      end else if (pos > SatHi) begin
        res <= COORD_BITS'(SatHi);
      end else if (pos < SatLo) begin
        res <= COORD_BITS'(SatLo);
      end else begin
        res <= COORD_BITS'(pos);
      end
    end
  end

endmodule

>>> hdl/triangle_transform_cull_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_transform_cull_project
// Rotates a triangle, culls back faces and projects kept triangles to screen.
// ----------------------------------------------------------------------------
// One triangle enters per clock while the output register is free or being
// emptied; the whole pipeline advances together and holds while the output
// register is full and not taken. The pipeline depth is set by the restoring
// dividers of the projection lanes, which resolve one of 38 quotient bits per
// stage. Three rotation lanes work on the corners, a merging stage forms the
// normal and the cull decision, and six projection lanes compute the screen
// coordinates. Culled triangles produce no output transaction but still
// restart the slot count when they carry frame_start. Configuration registers
// are read directly by the stages that use them: write them only while no
// triangle is in flight.
// ----------------------------------------------------------------------------
module triangle_transform_cull_project import ttc_pkg::*; (
  input  logic clk,
  input  logic rst,
  ttc_tri_if.sink   tri_in,
  ttc_scr_if.source tri_out,
  ttc_cfg_if.sink   cfg
);

  // Configuration registers
  logic [2:0][RegW-1:0] rot;
  logic [RegW-1:0]      camera;
  size_t                screen_w, screen_h, focal;

  // Pipeline control
  logic                 adv;
  logic                 vld   [LAST+1];
  logic                 fs    [LAST+1];
  logic                 keep_d [KEEP_IDX+1:LAST];
  logic                 keep;
  logic                 ov;
  logic [SLOT_BITS-1:0] slot_cnt;
  logic [SLOT_BITS-1:0] slot_base;

  tcoord_t tv [3][3];
  scoord_t sx [3], sy [3];
  logic    bx [3], by [3];

  // Advance whenever the output register is free or being emptied
  assign adv          = !ov || tri_out.ready;
  assign tri_in.ready = adv;
  assign cfg.ready    = 1'b1;
  assign tri_out.valid = ov;

  // Configuration decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]   <= RegW'(64'd16384);
      rot[1]   <= RegW'(64'd16384 << 16);
      rot[2]   <= RegW'(64'd16384 << 32);
      camera   <= '0;
      screen_w <= SizeW'(640);
      screen_h <= SizeW'(480);
      focal    <= SizeW'(640);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROT_X:  rot[0]   <= cfg.data;
        REG_ROT_Y:  rot[1]   <= cfg.data;
        REG_ROT_Z:  rot[2]   <= cfg.data;
        REG_CAMERA: camera   <= cfg.data;
        REG_WIDTH:  screen_w <= cfg.data[SizeW-1:0];
        REG_HEIGHT: screen_h <= cfg.data[SizeW-1:0];
        REG_FOCAL:  focal    <= cfg.data[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Corner lanes: rotation
  ttc_rotate_lane u_rot_a (.clk, .en(adv), .v_x(tri_in.vert_a_x), .v_y(tri_in.vert_a_y),
                           .v_z(tri_in.vert_a_z), .rot, .t(tv[0]));
  ttc_rotate_lane u_rot_b (.clk, .en(adv), .v_x(tri_in.vert_b_x), .v_y(tri_in.vert_b_y),
                           .v_z(tri_in.vert_b_z), .rot, .t(tv[1]));
  ttc_rotate_lane u_rot_c (.clk, .en(adv), .v_x(tri_in.vert_c_x), .v_y(tri_in.vert_c_y),
                           .v_z(tri_in.vert_c_z), .rot, .t(tv[2]));

  // Merge: back-face decision
  ttc_cull u_cull (.clk, .en(adv), .tv, .camera, .keep);

  // Projection lanes, x and y of each corner
  for (genvar k = 0; k < 3; k++) begin : g_proj
    ttc_proj_lane u_px (.clk, .en(adv), .c(tv[k][0]), .z(tv[k][2]), .focal,
                        .size(screen_w), .res(sx[k]), .behind(bx[k]));
    ttc_proj_lane u_py (.clk, .en(adv), .c(tv[k][1]), .z(tv[k][2]), .focal,
                        .size(screen_h), .res(sy[k]), .behind(by[k]));
  end

  // Valid, frame start and keep flags travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= tri_in.valid;
      for (int i = 1; i <= LAST; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fs[0] <= tri_in.frame_start;
      for (int i = 1; i <= LAST; i++) begin
        fs[i] <= fs[i-1];
      end
      keep_d[KEEP_IDX+1] <= keep;
      for (int i = KEEP_IDX + 2; i <= LAST; i++) begin
        keep_d[i] <= keep_d[i-1];
      end
    end
  end

  // Restart numbering on frame start, culled or not
  assign slot_base = fs[LAST] ? '0 : slot_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov       <= 1'b0;
      slot_cnt <= '0;
    end else if (adv) begin
      ov <= vld[LAST] && keep_d[LAST];
      if (vld[LAST]) begin
        slot_cnt <= keep_d[LAST] ? slot_base + 1'b1 : slot_base;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      tri_out.scr_a_x       <= sx[0];
      tri_out.scr_a_y       <= sy[0];
      tri_out.scr_b_x       <= sx[1];
      tri_out.scr_b_y       <= sy[1];
      tri_out.scr_c_x       <= sx[2];
      tri_out.scr_c_y       <= sy[2];
      tri_out.slot          <= slot_base;
      tri_out.behind_camera <= bx[0] | bx[1] | bx[2] | by[0];
    end
  end

  // Only a valid item fills the output register
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    (adv && !vld[LAST]) |=> !ov)
    else $error("output loaded from an empty stage");

  // Slot count holds while the pipeline is stalled
  a_slot_stall: assert property (@(posedge clk) disable iff (rst)
    (ov && !tri_out.ready) |=> $stable(slot_cnt))
    else $error("slot count moved during a stall");

  // Reset empties the output and restarts numbering
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> (!ov && slot_cnt == '0))
    else $error("output or slot count not cleared by reset");

endmodule

>>> dv/ttc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_checker
// Predicts the screen transactions of the triangle block from the triangle
// and configuration transactions it observes, and compares them field by field.
// ----------------------------------------------------------------------------
module ttc_checker import ttc_pkg::*; (
  input  logic clk,
  input  logic rst,
  ttc_tri_if   tri_in,
  ttc_scr_if   tri_out,
  ttc_cfg_if   cfg,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    scoord_t              ax, ay, bx, by, cx, cy;
    logic [SLOT_BITS-1:0] slot;
    logic                 behind;
  } screen_tri_t;

  screen_tri_t          screen_q[$];
  logic [RegW-1:0]      row_x, row_y, row_z, cam_pos;
  size_t                width, height, focal;
  logic [SLOT_BITS-1:0] next_slot;

  assign pending = screen_q.size();

  function automatic longint coef(logic [RegW-1:0] r, int k);
    return longint'($signed(r[16*k +: 16]));
  endfunction

  // floor division, divisor always positive here
  function automatic longint fdiv(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint rotate(logic [RegW-1:0] r, longint x, longint y, longint z);
    return fdiv(coef(r, 0) * x + coef(r, 1) * y + coef(r, 2) * z, 16384);
  endfunction

  function automatic scoord_t to_screen(longint c, longint z, size_t sz);
    longint r;
    longint hi;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    r = fdiv(c * longint'(focal) * 16, z) + longint'(sz) * 8;
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return scoord_t'(r);
  endfunction

  // Returns 1 and the screen triangle when the face is kept.
  function automatic bit project_tri(longint v[3][3], output screen_tri_t s);
    longint t[3][3];
    longint e1[3], e2[3], cv[3], n[3];
    longint dot;
    scoord_t sc[6];
    for (int k = 0; k < 3; k++) begin
      t[k][0] = rotate(row_x, v[k][0], v[k][1], v[k][2]);
      t[k][1] = rotate(row_y, v[k][0], v[k][1], v[k][2]);
      t[k][2] = rotate(row_z, v[k][0], v[k][1], v[k][2]) + ZOffset;
    end
    for (int k = 0; k < 3; k++) begin
      e1[k] = t[1][k] - t[0][k];
      e2[k] = t[2][k] - t[0][k];
      cv[k] = coef(cam_pos, k) - t[0][k];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    dot = n[0] * cv[0] + n[1] * cv[1] + n[2] * cv[2];
    s = '0;
    if (dot <= 0) return 0;
    for (int k = 0; k < 3; k++) begin
      if (t[k][2] <= 0) begin
        s.behind = 1'b1;
        sc[2*k] = '0;
        sc[2*k+1] = '0;
      end else begin
        sc[2*k] = to_screen(t[k][0], t[k][2], width);
        sc[2*k+1] = to_screen(t[k][1], t[k][2], height);
      end
    end
    {s.ax, s.ay, s.bx, s.by, s.cx, s.cy} = {sc[0], sc[1], sc[2], sc[3], sc[4], sc[5]};
    return 1;
  endfunction

  always @(posedge clk) begin
    longint v[3][3];
    screen_tri_t s, got;
    if (rst) begin
      row_x <= 48'd16384;
      row_y <= 48'd16384 << 16;
      row_z <= 48'd16384 << 32;
      cam_pos <= '0;
      width <= 12'd640;
      height <= 12'd480;
      focal <= 12'd640;
      next_slot = '0;
      mismatches <= 0;
      screen_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ROT_X:  row_x <= cfg.data;
          REG_ROT_Y:  row_y <= cfg.data;
          REG_ROT_Z:  row_z <= cfg.data;
          REG_CAMERA: cam_pos <= cfg.data;
          REG_WIDTH:  width <= cfg.data[SizeW-1:0];
          REG_HEIGHT: height <= cfg.data[SizeW-1:0];
          REG_FOCAL:  focal <= cfg.data[SizeW-1:0];
          default: ;  // unknown index: drop the write
        endcase
      end
      if (tri_in.valid && tri_in.ready) begin
        v[0] = '{tri_in.vert_a_x, tri_in.vert_a_y, tri_in.vert_a_z};
        v[1] = '{tri_in.vert_b_x, tri_in.vert_b_y, tri_in.vert_b_z};
        v[2] = '{tri_in.vert_c_x, tri_in.vert_c_y, tri_in.vert_c_z};
        // frame start restarts numbering even when the face is culled
        if (tri_in.frame_start) next_slot = '0;
        if (project_tri(v, s)) begin
          s.slot = next_slot;
          next_slot = next_slot + 1'b1;
          screen_q = {screen_q, s};
        end
      end
      if (tri_out.valid && tri_out.ready) begin
        got = '{tri_out.scr_a_x, tri_out.scr_a_y, tri_out.scr_b_x, tri_out.scr_b_y,
                tri_out.scr_c_x, tri_out.scr_c_y, tri_out.slot, tri_out.behind_camera};
        if (screen_q.size() == 0) begin
          if (mismatches < 10) $display("%0t: unexpected screen transaction %p", $realtime, got);
          mismatches <= mismatches + 1;
        end else begin
          s = screen_q.pop_front();
          if (got !== s) begin
            if (mismatches < 10)
              $display("%0t: screen mismatch\n  expected %p\n  actual   %p", $realtime, s, got);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives triangles and register writes into the transform, cull and project
// block under random idle and stall; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import ttc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;  // index with no register behind it
  localparam int SETTLE = 60;                // longer than the pipeline is deep

  typedef struct {
    vcoord_t v[9];
    logic    fs;
  } tri_item_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  bit   long_hold;      // ask the receiver for one long hold-off
  bit   rx_throttle;

  ttc_tri_if tri_in ();
  ttc_scr_if tri_out ();
  ttc_cfg_if cfg ();

  triangle_transform_cull_project dut (
    .clk(clk), .rst(rst), .tri_in(tri_in), .tri_out(tri_out), .cfg(cfg)
  );

  ttc_checker chk (
    .clk(clk), .rst(rst), .tri_in(tri_in), .tri_out(tri_out), .cfg(cfg),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold the whole run to a generous bound.
  initial begin
    #5ms;
    $display("** triangle_transform_cull_project: FAILED **");
    $finish;
  end

  // Receiver: stall on its own pattern, switching between throttled and open
  // stretches, and grant one long hold-off when asked.
  initial begin
    tri_out.ready = 1'b0;
    rx_throttle = 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        tri_out.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) rx_throttle = ~rx_throttle;
        tri_out.ready <= rx_throttle ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  // Offer one triangle and hold it until the block takes the transaction.
  task automatic send_tri(tri_item_t t);
    tri_in.valid <= 1'b1;
    {tri_in.vert_a_x, tri_in.vert_a_y, tri_in.vert_a_z} <= {t.v[0], t.v[1], t.v[2]};
    {tri_in.vert_b_x, tri_in.vert_b_y, tri_in.vert_b_z} <= {t.v[3], t.v[4], t.v[5]};
    {tri_in.vert_c_x, tri_in.vert_c_y, tri_in.vert_c_z} <= {t.v[6], t.v[7], t.v[8]};
    tri_in.frame_start <= t.fs;
    do @(posedge clk); while (!tri_in.ready);
  endtask

  task automatic idle_tri(int cycles);
    tri_in.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [RegW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected result has come out, then let culled items clear.
  task automatic drain();
    idle_tri(1);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic tri_item_t mk(int ax, int ay, int az, int bx, int by, int bz,
                                   int cx, int cy, int cz, bit fs);
    tri_item_t t;
    t.v = '{vcoord_t'(ax), vcoord_t'(ay), vcoord_t'(az), vcoord_t'(bx), vcoord_t'(by),
            vcoord_t'(bz), vcoord_t'(cx), vcoord_t'(cy), vcoord_t'(cz)};
    t.fs = fs;
    return t;
  endfunction

  // Mostly small, sensible triangles in front of the camera; some full-range noise.
  function automatic tri_item_t rand_tri();
    tri_item_t t;
    int span;
    span = ($urandom_range(0, 3) == 0) ? 32767 : 1024;
    for (int i = 0; i < 9; i++) begin
      if (span == 32767) t.v[i] = vcoord_t'($urandom());
      else t.v[i] = vcoord_t'(int'($urandom_range(0, 2 * span)) - span);
    end
    // push a corner behind the camera now and then
    if ($urandom_range(0, 15) == 0) t.v[3 * $urandom_range(0, 2) + 2] = -vcoord_t'(16'd2048);
    t.fs = ($urandom_range(0, 24) == 0);
    return t;
  endfunction

  function automatic logic [RegW-1:0] rand_row();
    logic [15:0] c[3];
    for (int i = 0; i < 3; i++)
      c[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
             16'(int'($urandom_range(0, 32768)) - 16384);
    return {c[2], c[1], c[0]};
  endfunction

  task automatic configure(logic [RegW-1:0] rx, logic [RegW-1:0] ry, logic [RegW-1:0] rz,
                           logic [RegW-1:0] cam, int w, int h, int f);
    write_reg(REG_ROT_X, rx);
    write_reg(REG_ROT_Y, ry);
    write_reg(REG_ROT_Z, rz);
    write_reg(REG_CAMERA, cam);
    write_reg(REG_WIDTH, RegW'(w));
    write_reg(REG_HEIGHT, RegW'(h));
    write_reg(REG_FOCAL, RegW'(f));
  endtask

  task automatic random_phase(int count, bit hold_once);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_tri(rand_tri());
        sent++;
        // keep offering while the receiver is held off
        if (hold_once && sent == count / 2) long_hold = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) idle_tri($urandom_range(1, 8));
      // pause at most once, when a burst ends at a quarter of the count, until the output side is empty
      if (sent == count / 4) drain();
    end
    drain();
  endtask

  localparam logic [RegW-1:0] ROW_X = 48'd16384;
  localparam logic [RegW-1:0] ROW_Y = 48'd16384 << 16;
  localparam logic [RegW-1:0] ROW_Z = 48'd16384 << 32;

  initial begin
    tri_item_t dir[$];
    rst = 1'b1;
    long_hold = 1'b0;
    tri_in.valid = 1'b0;
    {tri_in.vert_a_x, tri_in.vert_a_y, tri_in.vert_a_z} = '0;
    {tri_in.vert_b_x, tri_in.vert_b_y, tri_in.vert_b_z} = '0;
    {tri_in.vert_c_x, tri_in.vert_c_y, tri_in.vert_c_z} = '0;
    tri_in.frame_start = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: kept and culled faces, corners behind the camera, field extremes,
    // projection saturation and frame restarts, under reset configuration.
    dir = {dir, mk(0, 0, 0, 0, 256, 0, 256, 0, 0, 1)};            // front face
    dir = {dir, mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 0)};            // back face
    dir = {dir, mk(0, 0, 0, 0, 256, 0, 256, 0, 0, 0)};
    dir = {dir, mk(0, 0, -2048, 0, 256, 0, 256, 0, 0, 0)};        // corner behind
    dir = {dir, mk(0, 0, -1280, 0, 256, -1280, 256, 0, -1280, 0)}; // all at z = 0
    dir = {dir, mk(32767, 32767, -1279, 0, 256, 0, 256, 0, 0, 0)}; // culled before projection
    dir = {dir, mk(-32768, -32768, -1279, 0, 256, 0, 256, 0, 0, 0)}; // saturate low
    dir = {dir, mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, 0)};
    dir = {dir, mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, -32768, 0)};
    dir = {dir, mk(-32768, -32768, -32768, -32768, -32768, -32768, -1, -1, -1, 1)};
    dir = {dir, mk(0, 0, 0, 0, 256, 0, 256, 0, 0, 1)};            // restart while kept
    dir = {dir, mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 1)};            // restart while culled
    dir = {dir, mk(0, 0, 0, 0, 256, 0, 256, 0, 0, 0)};
    foreach (dir[i]) send_tri(dir[i]);
    drain();

    // Extreme sizes including zero, a shifted camera, and an unknown index.
    configure(ROW_X, ROW_Y, ROW_Z, {16'hFC00, 16'h0100, 16'hFF00}, 0, 4095, 4095);
    write_reg(REG_UNUSED, '1);
    foreach (dir[i]) send_tri(dir[i]);
    drain();

    configure(ROW_X, ROW_Y, ROW_Z, '0, 640, 480, 640);
    random_phase(300, 1'b1);

    configure(rand_row(), rand_row(), rand_row(), '0, 1, 1, 1);
    random_phase(300, 1'b0);

    configure(rand_row(), rand_row(), rand_row(), {16'($urandom()), 16'($urandom()),
              16'($urandom())}, 4095, 4095, 4095);
    random_phase(300, 1'b1);

    configure({16'hC000, 16'h7FFF, 16'h8000}, {16'h3FFF, 16'hFFFF, 16'h0001},
              {16'h4000, 16'h0000, 16'h0000}, {16'h7FFF, 16'h8000, 16'h7FFF},
              $urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(1, 4095));
    random_phase(300, 1'b0);

    if (mismatches == 0 && pending == 0) begin
      $display("** triangle_transform_cull_project: PASSED **");
    end else begin
      $display("** triangle_transform_cull_project: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/ttc_pkg.sv
hdl/ttc_chan_if.sv
hdl/ttc_rotate_lane.sv
hdl/ttc_cull.sv
hdl/ttc_proj_lane.sv
hdl/triangle_transform_cull_project.sv
dv/ttc_checker.sv
dv/tb.sv
